@@ rtl/core/sbc_pkg.sv @@
// ----------------------------------------------------------------------------
// sbc_pkg: shared definitions for the swept box collision time unit
// Constants, field widths, normal codes and queue status type.
// ----------------------------------------------------------------------------
`default_nettype none

package sbc_pkg;

  localparam int COORD_BITS_DEF     = 16;
  localparam int VEL_FRAC_BITS_DEF  = 8;
  localparam int TIME_FRAC_BITS_DEF = 16;

  localparam int VEL_BITS = 24;
  localparam int HT_W     = 17;
  localparam int NRM_W    = 2;
  localparam int Q_DEPTH  = 4;

  localparam logic [NRM_W-1:0] NRM_ZERO = 2'b00;
  localparam logic [NRM_W-1:0] NRM_POS  = 2'b01;
  localparam logic [NRM_W-1:0] NRM_NEG  = 2'b11;

  typedef struct packed {
    logic full;
    logic empty;
  } sbc_q_stat_t;

  // Width of one classified item for a given coordinate width.
  function automatic int item_bits(input int coord_bits);
    return 4 * (coord_bits + 1) + 2 * VEL_BITS + 8;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/sbc_if.sv @@
// ----------------------------------------------------------------------------
// sbc_if: channel interfaces of the swept box collision time unit
// Valid/ready channels for box pairs and for collision results.
// ----------------------------------------------------------------------------
`default_nettype none

interface sbc_in_if #(
  parameter int COORD_BITS = sbc_pkg::COORD_BITS_DEF
);
  logic                             valid;
  logic                             ready;
  logic signed [COORD_BITS-1:0]     moving_x;
  logic signed [COORD_BITS-1:0]     moving_y;
  logic [COORD_BITS-2:0]            moving_w;
  logic [COORD_BITS-2:0]            moving_h;
  logic signed [sbc_pkg::VEL_BITS-1:0] vel_x;
  logic signed [sbc_pkg::VEL_BITS-1:0] vel_y;
  logic signed [COORD_BITS-1:0]     other_x;
  logic signed [COORD_BITS-1:0]     other_y;
  logic [COORD_BITS-2:0]            other_w;
  logic [COORD_BITS-2:0]            other_h;

  modport source (output valid, moving_x, moving_y, moving_w, moving_h, vel_x, vel_y,
                  other_x, other_y, other_w, other_h, input ready);
  modport sink (input valid, moving_x, moving_y, moving_w, moving_h, vel_x, vel_y,
                other_x, other_y, other_w, other_h, output ready);
endinterface

interface sbc_out_if;
  logic                                valid;
  logic                                ready;
  logic                                hit;
  logic [sbc_pkg::HT_W-1:0]            hit_time;
  logic signed [sbc_pkg::NRM_W-1:0]    normal_x;
  logic signed [sbc_pkg::NRM_W-1:0]    normal_y;

  modport source (output valid, hit, hit_time, normal_x, normal_y, input ready);
  modport sink (input valid, hit, hit_time, normal_x, normal_y, output ready);
endinterface

`default_nettype wire

@@ rtl/core/swept_box_collision_time_unit.sv @@
// ----------------------------------------------------------------------------
// swept_box_collision_time_unit: swept box collision time
// Contact time and face normal of a moving box against a static box.
// Path from transfer in to result valid: the queue, the divider stages,
// the key register, the compare register and the output register.
// Throughput: one box pair per cycle while results are taken; the divider pipelines take one
// quotient bit per stage and stall together when the result is not taken.
// Reset clears the queue and all valid flags; no item is in flight after it.
// ----------------------------------------------------------------------------
`default_nettype none

module swept_box_collision_time_unit #(
  parameter int COORD_BITS     = sbc_pkg::COORD_BITS_DEF,
  parameter int VEL_FRAC_BITS  = sbc_pkg::VEL_FRAC_BITS_DEF,
  parameter int TIME_FRAC_BITS = sbc_pkg::TIME_FRAC_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  sbc_in_if.sink     in_chan,
  sbc_out_if.source  out_chan
);
  import sbc_pkg::*;

  localparam int IW = item_bits(COORD_BITS);

  logic [IW-1:0] push_item, pop_item;
  sbc_q_stat_t   q_stat;
  logic          pop;

  assign in_chan.ready = !q_stat.full;

  sbc_front #(.COORD_BITS(COORD_BITS)) u_front (
    .moving_x(in_chan.moving_x), .moving_y(in_chan.moving_y),
    .moving_w(in_chan.moving_w), .moving_h(in_chan.moving_h),
    .vel_x(in_chan.vel_x), .vel_y(in_chan.vel_y),
    .other_x(in_chan.other_x), .other_y(in_chan.other_y),
    .other_w(in_chan.other_w), .other_h(in_chan.other_h),
    .item(push_item)
  );

  sbc_queue #(.WIDTH(IW), .DEPTH(Q_DEPTH)) u_queue (
    .clk(clk), .rst_n(rst_n),
    .push(in_chan.valid), .push_data(push_item),
    .pop(pop), .pop_data(pop_item), .stat(q_stat)
  );

  sbc_back #(
    .COORD_BITS(COORD_BITS), .VEL_FRAC_BITS(VEL_FRAC_BITS),
    .TIME_FRAC_BITS(TIME_FRAC_BITS)
  ) u_back (
    .clk(clk), .rst_n(rst_n), .item(pop_item), .q_stat(q_stat), .pop(pop),
    .out_valid(out_chan.valid), .out_ready(out_chan.ready),
    .out_hit(out_chan.hit), .out_hit_time(out_chan.hit_time),
    .out_normal_x(out_chan.normal_x), .out_normal_y(out_chan.normal_y)
  );

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_chan.valid)
    else $error("result valid right after reset");

  a_miss_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && !out_chan.hit |->
      out_chan.normal_x == NRM_ZERO && out_chan.normal_y == NRM_ZERO)
    else $error("miss with a nonzero normal");

  a_hit_normal: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.hit |->
      ((out_chan.normal_x != NRM_ZERO) != (out_chan.normal_y != NRM_ZERO)))
    else $error("hit without exactly one normal axis");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("pipeline took an item from an empty queue");

endmodule

`default_nettype wire

@@ rtl/core/sbc_front.sv @@
// ----------------------------------------------------------------------------
// sbc_front: box pair classification
// Picks entry and exit gaps from the velocity signs and splits them into
// magnitudes and sign flags for the divider pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module sbc_front #(
  parameter int COORD_BITS = sbc_pkg::COORD_BITS_DEF
) (
  input  wire logic signed [COORD_BITS-1:0]        moving_x,
  input  wire logic signed [COORD_BITS-1:0]        moving_y,
  input  wire logic [COORD_BITS-2:0]               moving_w,
  input  wire logic [COORD_BITS-2:0]               moving_h,
  input  wire logic signed [sbc_pkg::VEL_BITS-1:0] vel_x,
  input  wire logic signed [sbc_pkg::VEL_BITS-1:0] vel_y,
  input  wire logic signed [COORD_BITS-1:0]        other_x,
  input  wire logic signed [COORD_BITS-1:0]        other_y,
  input  wire logic [COORD_BITS-2:0]               other_w,
  input  wire logic [COORD_BITS-2:0]               other_h,
  output logic [sbc_pkg::item_bits(COORD_BITS)-1:0] item
);
  import sbc_pkg::*;

  localparam int GW = COORD_BITS + 2;
  localparam int MW = GW - 1;

  typedef struct packed {
    logic [MW-1:0]       mxe;
    logic [MW-1:0]       mxx;
    logic [MW-1:0]       mye;
    logic [MW-1:0]       myx;
    logic [VEL_BITS-1:0] dx;
    logic [VEL_BITS-1:0] dy;
    logic                nxe;
    logic                nxx;
    logic                nye;
    logic                nyx;
    logic                gxe_neg;
    logic                gye_neg;
    logic                zx;
    logic                zy;
  } item_t;

  logic signed [GW-1:0] mx, my, ox, oy, mr, mb, orr, ob;
  logic signed [GW-1:0] gxe, gxx, gye, gyx;
  logic                 vx_pos, vy_pos;
  item_t                it;

  function automatic logic [MW-1:0] mag(input logic signed [GW-1:0] g);
    logic signed [GW-1:0] a;
    a = g[GW-1] ? -g : g;
    return a[MW-1:0];
  endfunction

  assign mx  = {{2{moving_x[COORD_BITS-1]}}, moving_x};
  assign my  = {{2{moving_y[COORD_BITS-1]}}, moving_y};
  assign ox  = {{2{other_x[COORD_BITS-1]}}, other_x};
  assign oy  = {{2{other_y[COORD_BITS-1]}}, other_y};
  assign mr  = mx + {3'b000, moving_w};
  assign mb  = my + {3'b000, moving_h};
  assign orr = ox + {3'b000, other_w};
  assign ob  = oy + {3'b000, other_h};

  assign vx_pos = !vel_x[VEL_BITS-1] && (vel_x != '0);
  assign vy_pos = !vel_y[VEL_BITS-1] && (vel_y != '0);

  always_comb begin
    if (vx_pos) begin
      gxe = ox - mr;
      gxx = orr - mx;
    end else begin
      gxe = orr - mx;
      gxx = ox - mr;
    end
    if (vy_pos) begin
      gye = oy - mb;
      gyx = ob - my;
    end else begin
      gye = ob - my;
      gyx = oy - mb;
    end
  end

  always_comb begin
    it.mxe     = mag(gxe);
    it.mxx     = mag(gxx);
    it.mye     = mag(gye);
    it.myx     = mag(gyx);
    it.dx      = vel_x[VEL_BITS-1] ? -vel_x : vel_x;
    it.dy      = vel_y[VEL_BITS-1] ? -vel_y : vel_y;
    it.nxe     = gxe[GW-1] ^ vel_x[VEL_BITS-1];
    it.nxx     = gxx[GW-1] ^ vel_x[VEL_BITS-1];
    it.nye     = gye[GW-1] ^ vel_y[VEL_BITS-1];
    it.nyx     = gyx[GW-1] ^ vel_y[VEL_BITS-1];
    it.gxe_neg = gxe[GW-1];
    it.gye_neg = gye[GW-1];
    it.zx      = (vel_x == '0);
    it.zy      = (vel_y == '0);
  end

  assign item = it;

endmodule

`default_nettype wire

@@ rtl/core/sbc_queue.sv @@
// ----------------------------------------------------------------------------
// sbc_queue: short decoupling queue
// Register based first-in first-out queue between classification and the
// divider pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module sbc_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = sbc_pkg::Q_DEPTH
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire logic [WIDTH-1:0]     push_data,
  input  wire logic                 pop,
  output logic [WIDTH-1:0]          pop_data,
  output sbc_pkg::sbc_q_stat_t      stat
);
  import sbc_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]      cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign stat.full  = (cnt_r == (AW+1)'(DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_data   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    cnt_nxt = cnt_r + (AW+1)'(do_push) - (AW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/sbc_div.sv @@
// ----------------------------------------------------------------------------
// sbc_div: pipelined unsigned divider
// Restoring division, one quotient bit per stage, with a common stall.
// ----------------------------------------------------------------------------
`default_nettype none

module sbc_div #(
  parameter int NW = 41,
  parameter int DW = 24
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic [NW-1:0]      quo,
  output logic               rem_nz
);
  import sbc_pkg::*;

  logic [NW-1:0] num_r [NW];
  logic [DW-1:0] den_r [NW];
  logic [DW-1:0] rem_r [NW];
  logic [NW-1:0] quo_r [NW];

  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic [NW-1:0] num_p, quo_p;
    logic [DW-1:0] den_p, rem_p;
    logic [DW:0]   trial;
    logic          ge;

    if (s == 0) begin : g_first
      assign num_p = num;
      assign den_p = den;
      assign rem_p = '0;
      assign quo_p = '0;
    end else begin : g_next
      assign num_p = num_r[s-1];
      assign den_p = den_r[s-1];
      assign rem_p = rem_r[s-1];
      assign quo_p = quo_r[s-1];
    end

    assign trial = {rem_p, num_p[NW-1-s]};
    assign ge    = (trial >= {1'b0, den_p});

    always_ff @(posedge clk) begin
      if (en) begin
        num_r[s] <= num_p;
        den_r[s] <= den_p;
        rem_r[s] <= ge ? DW'(trial - {1'b0, den_p}) : trial[DW-1:0];
        quo_r[s] <= {quo_p[NW-2:0], ge};
      end
    end
  end

  assign quo    = quo_r[NW-1];
  assign rem_nz = (rem_r[NW-1] != '0);

endmodule

`default_nettype wire

@@ rtl/core/sbc_back.sv @@
// ----------------------------------------------------------------------------
// sbc_back: time computation and contact decision
// Four divider pipelines and a key register form the time keys; a compare register
// compares them and an output register holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module sbc_back #(
  parameter int COORD_BITS     = sbc_pkg::COORD_BITS_DEF,
  parameter int VEL_FRAC_BITS  = sbc_pkg::VEL_FRAC_BITS_DEF,
  parameter int TIME_FRAC_BITS = sbc_pkg::TIME_FRAC_BITS_DEF
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst_n,
  input  wire logic [sbc_pkg::item_bits(COORD_BITS)-1:0] item,
  input  wire sbc_pkg::sbc_q_stat_t                      q_stat,
  output logic                                          pop,
  output logic                                          out_valid,
  input  wire logic                                     out_ready,
  output logic                                          out_hit,
  output logic [sbc_pkg::HT_W-1:0]                      out_hit_time,
  output logic signed [sbc_pkg::NRM_W-1:0]              out_normal_x,
  output logic signed [sbc_pkg::NRM_W-1:0]              out_normal_y
);
  import sbc_pkg::*;

  localparam int GW  = COORD_BITS + 2;
  localparam int MW  = GW - 1;
  localparam int SH  = VEL_FRAC_BITS + TIME_FRAC_BITS;
  localparam int QW  = MW + SH;
  localparam int KW  = ((QW + 1 > TIME_FRAC_BITS + 26) ? QW + 1 : TIME_FRAC_BITS + 26) + 1;

  localparam logic signed [KW-1:0] QSAT    = KW'(1) << (TIME_FRAC_BITS + 24);
  localparam logic signed [KW-1:0] KEY_SAT = (KW'(1) << (TIME_FRAC_BITS + 25)) + KW'(1);
  localparam logic signed [KW-1:0] KEY_INF = (KW'(1) << (TIME_FRAC_BITS + 25)) + KW'(3);
  localparam logic signed [KW-1:0] KEY_ONE = KW'(2) << TIME_FRAC_BITS;
  localparam logic [KW-1:0]        T_ONE   = KW'(1) << TIME_FRAC_BITS;

  typedef struct packed {
    logic [MW-1:0]       mxe;
    logic [MW-1:0]       mxx;
    logic [MW-1:0]       mye;
    logic [MW-1:0]       myx;
    logic [VEL_BITS-1:0] dx;
    logic [VEL_BITS-1:0] dy;
    logic                nxe;
    logic                nxx;
    logic                nye;
    logic                nyx;
    logic                gxe_neg;
    logic                gye_neg;
    logic                zx;
    logic                zy;
  } item_t;

  typedef struct packed {
    logic nxe;
    logic nxx;
    logic nye;
    logic nyx;
    logic gxe_neg;
    logic gye_neg;
    logic zx;
    logic zy;
  } side_t;

  item_t             it;
  logic              en;
  logic              v_r [QW];
  side_t             sb_r [QW];
  logic [QW-1:0]     q_xe, q_xx, q_ye, q_yx;
  logic              r_xe, r_xx, r_ye, r_yx;

  logic              kv_r;
  logic signed [KW-1:0] kxe_r, kxx_r, kye_r, kyx_r;
  logic              kgx_r, kgy_r;

  logic              cv_r, cxgt_r, cbneg_r, cover_r, cgx_r, cgy_r;
  logic signed [KW-1:0] ent_r, lev_r;

  logic              out_valid_r, out_hit_r;
  logic [HT_W-1:0]   out_time_r;
  logic [NRM_W-1:0]  out_nx_r, out_ny_r;

  logic              miss;

  assign it  = item;
  assign en  = !out_valid_r || out_ready;
  assign pop = en && !q_stat.empty;

  function automatic logic signed [KW-1:0] mk_key(input logic [QW-1:0] q, input logic nz,
                                                 input logic neg, input logic zv);
    logic [KW-1:0]        mq;
    logic signed [KW-1:0] m;
    mq = {{(KW-QW){1'b0}}, q};
    m  = (mq > QSAT) ? KEY_SAT : signed'((mq << 1) + KW'(nz));
    if (zv) begin
      return neg ? KEY_INF : -KEY_INF;
    end
    return neg ? -m : m;
  endfunction

  sbc_div #(.NW(QW), .DW(VEL_BITS)) u_div_xe (
    .clk(clk), .en(en), .num({it.mxe, {SH{1'b0}}}), .den(it.dx), .quo(q_xe), .rem_nz(r_xe));
  sbc_div #(.NW(QW), .DW(VEL_BITS)) u_div_xx (
    .clk(clk), .en(en), .num({it.mxx, {SH{1'b0}}}), .den(it.dx), .quo(q_xx), .rem_nz(r_xx));
  sbc_div #(.NW(QW), .DW(VEL_BITS)) u_div_ye (
    .clk(clk), .en(en), .num({it.mye, {SH{1'b0}}}), .den(it.dy), .quo(q_ye), .rem_nz(r_ye));
  sbc_div #(.NW(QW), .DW(VEL_BITS)) u_div_yx (
    .clk(clk), .en(en), .num({it.myx, {SH{1'b0}}}), .den(it.dy), .quo(q_yx), .rem_nz(r_yx));

  // Sideband and valid travel alongside the divider stages.
  for (genvar s = 0; s < QW; s++) begin : g_side
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= (s == 0) ? pop : v_r[(s == 0) ? 0 : s-1];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (s == 0) begin
          sb_r[s] <= {it.nxe, it.nxx, it.nye, it.nyx, it.gxe_neg, it.gye_neg, it.zx, it.zy};
        end else begin
          sb_r[s] <= sb_r[(s == 0) ? 0 : s-1];
        end
      end
    end
  end

  // The entry sign flag is cleared when the velocity is zero, so the zero-velocity
  // flag with a positive sign selects minus infinity for the entry keys.
  always_ff @(posedge clk) begin
    if (en) begin
      kxe_r <= mk_key(q_xe, r_xe, sb_r[QW-1].nxe && !sb_r[QW-1].zx, sb_r[QW-1].zx);
      kxx_r <= mk_key(q_xx, r_xx, sb_r[QW-1].nxx || sb_r[QW-1].zx, sb_r[QW-1].zx);
      kye_r <= mk_key(q_ye, r_ye, sb_r[QW-1].nye && !sb_r[QW-1].zy, sb_r[QW-1].zy);
      kyx_r <= mk_key(q_yx, r_yx, sb_r[QW-1].nyx || sb_r[QW-1].zy, sb_r[QW-1].zy);
      kgx_r <= sb_r[QW-1].gxe_neg;
      kgy_r <= sb_r[QW-1].gye_neg;
      cxgt_r  <= kxe_r > kye_r;
      ent_r   <= (kxe_r > kye_r) ? kxe_r : kye_r;
      lev_r   <= (kxx_r < kyx_r) ? kxx_r : kyx_r;
      cbneg_r <= kxe_r[KW-1] && kye_r[KW-1];
      cover_r <= (kxe_r > KEY_ONE) || (kye_r > KEY_ONE);
      cgx_r   <= kgx_r;
      cgy_r   <= kgy_r;
    end
  end

  assign miss = (ent_r > lev_r) || cbneg_r || cover_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kv_r        <= 1'b0;
      cv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      kv_r        <= v_r[QW-1];
      cv_r        <= kv_r;
      out_valid_r <= cv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (miss) begin
        out_hit_r  <= 1'b0;
        out_time_r <= T_ONE[HT_W-1:0];
        out_nx_r   <= NRM_ZERO;
        out_ny_r   <= NRM_ZERO;
      end else begin
        out_hit_r  <= 1'b1;
        out_time_r <= ent_r[HT_W:1];
        out_nx_r   <= cxgt_r ? (cgx_r ? NRM_POS : NRM_NEG) : NRM_ZERO;
        out_ny_r   <= cxgt_r ? NRM_ZERO : (cgy_r ? NRM_POS : NRM_NEG);
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_hit      = out_hit_r;
  assign out_hit_time = out_time_r;
  assign out_normal_x = out_nx_r;
  assign out_normal_y = out_ny_r;

endmodule

`default_nettype wire
